// ===== rtl/jpdtc_pkg.sv =====
`timescale 1ns / 1ps

package jpdtc_pkg;

  localparam int NUM_JOINTS = 32;

  localparam int JOINT_W = 5;
  localparam int POS_W   = 16;
  localparam int STICK_W = 16;
  localparam int TORQ_W  = 32;
  localparam int DB_W    = 15;
  localparam int GAIN_W  = 16;
  localparam int MASK_W  = 32;

  // stream word widths, padded to whole bytes
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 40;

  localparam int ADDR_W = 5;
  localparam int APB_W  = 32;

  // floor(u / 5) = (u * RECIP5) >> RECIP5_SH, exact for u < 2**18
  localparam logic [16:0] RECIP5    = 17'd52429;
  localparam int          RECIP5_SH = 18;
  // bias that keeps the divide-by-5 operand non-negative (a multiple of 5)
  localparam int          DIV_BIAS  = 45060;
  localparam int          DIV_BIASQ = DIV_BIAS / 5;

  localparam logic [2:0] REG_DEADBAND   = 3'd0;
  localparam logic [2:0] REG_INV_TS     = 3'd1;
  localparam logic [2:0] REG_GAIN_P_HI  = 3'd2;
  localparam logic [2:0] REG_GAIN_P_LO  = 3'd3;
  localparam logic [2:0] REG_GAIN_D     = 3'd4;
  localparam logic [2:0] REG_HI_MASK    = 3'd5;
  localparam logic [2:0] REG_PLUS_MASK  = 3'd6;
  localparam logic [2:0] REG_MINUS_MASK = 3'd7;

  typedef struct packed {
    logic [DB_W-1:0]   deadband;
    logic [GAIN_W-1:0] inv_timestep;
    logic [GAIN_W-1:0] gain_p_high;
    logic [GAIN_W-1:0] gain_p_low;
    logic [GAIN_W-1:0] gain_d;
    logic [MASK_W-1:0] high_gain_mask;
    logic [MASK_W-1:0] plus_offset_mask;
    logic [MASK_W-1:0] minus_offset_mask;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RECIP,
    MUL_P,
    MUL_V,
    MUL_D
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    ld_u;
    logic    ld_q;
    logic    ld_p;
    logic    out_ld;
    mul_op_t mul_op;
  } cmd_t;

  typedef struct packed {
    logic in_ctrl;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/jpdtc_regs.sv =====
`timescale 1ns / 1ps

module jpdtc_regs
  import jpdtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband          <= 15'd3277;
      cfg.inv_timestep      <= 16'd1000;
      cfg.gain_p_high       <= 16'd8000;
      cfg.gain_p_low        <= 16'd3000;
      cfg.gain_d            <= 16'd100;
      cfg.high_gain_mask    <= 32'h1C07_E03F;
      cfg.plus_offset_mask  <= '0;
      cfg.minus_offset_mask <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEADBAND:   cfg.deadband          <= pwdata[DB_W-1:0];
        REG_INV_TS:     cfg.inv_timestep      <= pwdata[GAIN_W-1:0];
        REG_GAIN_P_HI:  cfg.gain_p_high       <= pwdata[GAIN_W-1:0];
        REG_GAIN_P_LO:  cfg.gain_p_low        <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:     cfg.gain_d            <= pwdata[GAIN_W-1:0];
        REG_HI_MASK:    cfg.high_gain_mask    <= pwdata[MASK_W-1:0];
        REG_PLUS_MASK:  cfg.plus_offset_mask  <= pwdata[MASK_W-1:0];
        REG_MINUS_MASK: cfg.minus_offset_mask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEADBAND:   prdata = APB_W'(cfg.deadband);
      REG_INV_TS:     prdata = APB_W'(cfg.inv_timestep);
      REG_GAIN_P_HI:  prdata = APB_W'(cfg.gain_p_high);
      REG_GAIN_P_LO:  prdata = APB_W'(cfg.gain_p_low);
      REG_GAIN_D:     prdata = APB_W'(cfg.gain_d);
      REG_HI_MASK:    prdata = cfg.high_gain_mask;
      REG_PLUS_MASK:  prdata = cfg.plus_offset_mask;
      REG_MINUS_MASK: prdata = cfg.minus_offset_mask;
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/jpdtc_ctrl.sv =====
`timescale 1ns / 1ps

module jpdtc_ctrl
  import jpdtc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM,
    S_RECIP,
    S_OFFS,
    S_MULP,
    S_MULV,
    S_MULD,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          // capture words finish at accept
          if (accept && stat.in_ctrl) state <= S_NUM;
        end
        S_NUM:   state <= S_RECIP;
        S_RECIP: state <= S_OFFS;
        S_OFFS:  state <= S_MULP;
        S_MULP:  state <= S_MULV;
        S_MULV:  state <= S_MULD;
        S_MULD:  state <= S_OUT;
        S_OUT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_op  = MUL_NONE;
    cmd.load_in = accept;
    unique case (state)
      S_IDLE:  ;
      S_NUM:   cmd.ld_u   = 1'b1;
      S_RECIP: cmd.mul_op = MUL_RECIP;
      S_OFFS:  cmd.ld_q   = 1'b1;
      S_MULP:  cmd.mul_op = MUL_P;
      S_MULV: begin
        cmd.mul_op = MUL_V;
        cmd.ld_p   = 1'b1;
      end
      S_MULD:  cmd.mul_op = MUL_D;
      S_OUT:   cmd.out_ld = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/jpdtc_dp.sv =====
`timescale 1ns / 1ps

module jpdtc_dp
  import jpdtc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  function automatic logic signed [STICK_W-1:0] db_apply(
    input logic signed [STICK_W-1:0] a,
    input logic [DB_W-1:0]           th
  );
    logic signed [STICK_W:0] ext;
    logic signed [STICK_W:0] mag;
    ext = STICK_W'(a) == '0 ? '0 : (STICK_W+1)'(a);
    mag = (ext < 0) ? -ext : ext;
    return ($unsigned(mag) < (STICK_W+1)'(th)) ? '0 : a;
  endfunction

  // per-joint state, contents undefined until captured
  logic signed [POS_W-1:0] ref_mem  [NUM_JOINTS];
  logic signed [POS_W-1:0] last_mem [NUM_JOINTS];

  logic [JOINT_W-1:0]        in_joint;
  logic signed [POS_W-1:0]   in_pos;
  logic signed [STICK_W-1:0] in_sx;
  logic signed [STICK_W-1:0] in_sy;
  logic                      joint_ok;
  logic                      cap_wr;

  logic [JOINT_W-1:0]        j_r;
  logic signed [POS_W-1:0]   pos_r;
  logic signed [STICK_W-1:0] sx_r;
  logic signed [STICK_W-1:0] sy_r;
  logic signed [POS_W-1:0]   ref_rd;
  logic signed [POS_W-1:0]   last_rd;
  logic [16:0]               u_r;
  logic signed [POS_W-1:0]   q_r;
  logic signed [33:0]        p_r;
  logic signed [50:0]        prod;

  logic signed [19:0] num;
  logic signed [17:0] u_w;
  logic signed [17:0] off;
  logic signed [17:0] delta;
  logic signed [18:0] qsum;
  logic signed [POS_W-1:0] q_sat;
  logic               plus_b;
  logic               minus_b;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_res;
  logic signed [16:0] err;
  logic signed [16:0] dpos;
  logic [GAIN_W-1:0]  kp;

  logic signed [51:0]       u_full;
  logic signed [TORQ_W-1:0] torque;

  assign in_joint = s_tdata[4:0];
  assign in_pos   = $signed(s_tdata[20:5]);
  assign in_sx    = $signed(s_tdata[36:21]);
  assign in_sy    = $signed(s_tdata[52:37]);
  assign joint_ok = (int'(in_joint) < NUM_JOINTS);
  assign cap_wr   = cmd.load_in && !s_tuser && joint_ok;

  assign stat.in_ctrl  = s_tuser && joint_ok;
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cap_wr) ref_mem[in_joint] <= in_pos;
  end

  always_ff @(posedge clk) begin
    if (cap_wr) begin
      last_mem[in_joint] <= in_pos;
    end else if (cmd.out_ld) begin
      last_mem[j_r] <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      j_r     <= in_joint;
      pos_r   <= in_pos;
      sx_r    <= db_apply(in_sx, cfg.deadband);
      sy_r    <= db_apply(in_sy, cfg.deadband);
      ref_rd  <= ref_mem[in_joint];
      last_rd <= last_mem[in_joint];
    end
  end

  // offset = floor((10*x + y + 20) / 40) = floor(floor(n / 8) / 5)
  always_comb begin
    num = (20'(sx_r) <<< 3) + (20'(sx_r) <<< 1) + 20'(sy_r) + 20'sd20;
    u_w = 18'(num >>> 3) + 18'(DIV_BIAS);
  end

  always_comb begin
    off     = $signed({1'b0, prod[RECIP5_SH+16:RECIP5_SH]}) - 18'(DIV_BIASQ);
    plus_b  = cfg.plus_offset_mask[j_r];
    minus_b = cfg.minus_offset_mask[j_r];
    if (plus_b && !minus_b) begin
      delta = off;
    end else if (minus_b && !plus_b) begin
      delta = -off;
    end else begin
      delta = '0;
    end
    qsum = 19'(pos_r) + 19'(delta);
    if (qsum > 19'sd32767) begin
      q_sat = 16'sh7FFF;
    end else if (qsum < -19'sd32768) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = qsum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_u) u_r <= u_w[16:0];
    if (cmd.ld_q) q_r <= q_sat;
    if (cmd.ld_p) p_r <= prod[33:0];
  end

  // shared multiplier, one product per step
  assign err  = ref_rd - q_r;
  assign dpos = q_r - last_rd;
  assign kp   = cfg.high_gain_mask[j_r] ? cfg.gain_p_high : cfg.gain_p_low;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_RECIP: begin
        mul_a = $signed({17'b0, u_r});
        mul_b = $signed(RECIP5);
      end
      MUL_P: begin
        mul_a = 34'(err);
        mul_b = $signed({1'b0, kp});
      end
      MUL_V: begin
        mul_a = 34'(dpos);
        mul_b = $signed({1'b0, cfg.inv_timestep});
      end
      MUL_D: begin
        mul_a = prod[33:0];
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) prod <= mul_res;
  end

  always_comb begin
    u_full = 52'(p_r) - 52'(prod);
    if (u_full > 52'sd2147483647) begin
      torque = 32'sh7FFF_FFFF;
    end else if (u_full < -52'sd2147483648) begin
      torque = 32'sh8000_0000;
    end else begin
      torque = u_full[TORQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) m_tdata <= {3'b0, torque, j_r};
  end

endmodule

// ===== rtl/joint_pd_torque_controller.sv =====
`timescale 1ns / 1ps

// Multi-joint PD torque controller.
// Input stream (s_*): one word per joint sample. s_tuser is the action:
// 0 captures the position as the joint's reference and last position and
// gives no output word; 1 runs the control law and gives one output word.
// Output stream (m_*): joint index and saturated 32-bit torque.
// Configuration: APB registers at 4*i (deadband, inv_timestep, gains, masks);
// write only while the block is idle.
// Flow: a control word is accepted, then passes through the NUM, RECIP, OFFS,
// MULP, MULV, MULD and OUT states with one shared 34x17 multiplier (reciprocal
// divide, Kp, velocity, Kd products); the output word is loaded in OUT. One word
// is worked on at a time: a control word keeps the block busy until it leaves
// OUT, and a capture word finishes at accept.
// The result sits in an output register, so the next word is taken while a
// result waits; if m_tready stays low the block holds in its last step.
// Reset clears control state and the registers to their defaults; the joint
// tables are not cleared, every joint must be captured before control.
module joint_pd_torque_controller
  import jpdtc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // joint_index[4:0], position[20:5],
                                        // stick_x[36:21], stick_y[52:37]
  input  logic                s_tuser,  // action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // joint_out[4:0], torque[36:5]
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]    prdata,
  output logic                pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  jpdtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jpdtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jpdtc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/jpdtc_chk.sv =====
`timescale 1ns / 1ps

module jpdtc_chk
  import jpdtc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed under stall");

  // a control word occupies the block
  a_ctrl_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken during control computation");

  // a capture word finishes at accept
  a_cap_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("capture word kept the block busy");

  // a new result only comes out of the last compute step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("output word without a control computation");

endmodule

bind joint_pd_torque_controller jpdtc_chk u_chk (.*);
